### rtl/onc_pkg.sv
// shared constants and codes for the octahedral normal codec
package onc_pkg;

   // fixed field and register widths
   localparam int CODE_W = 16;
   localparam int CFG_W  = 5;

   // code_bits register lower limit and reset value
   localparam logic [CFG_W-1:0] CODE_BITS_RESET = 5'd16;
   localparam logic [CFG_W-1:0] CODE_BITS_MIN   = 5'd8;

   // action codes of a request beat
   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

endpackage

### rtl/onc_req_if.sv
// request channel: one vector to encode or one code to decode per beat
interface onc_req_if #(
   parameter int COMPONENT_BITS = 16
) ();
   import onc_pkg::*;

   logic                             valid;
   logic                             ready;
   logic                             action;
   logic signed [COMPONENT_BITS-1:0] x_in;
   logic signed [COMPONENT_BITS-1:0] y_in;
   logic signed [COMPONENT_BITS-1:0] z_in;
   logic [CODE_W-1:0]                code_in;

   modport source (output valid, action, x_in, y_in, z_in, code_in, input ready);
   modport sink   (input valid, action, x_in, y_in, z_in, code_in, output ready);
endinterface

### rtl/onc_rsp_if.sv
// response channel: one code or one unit vector per beat
interface onc_rsp_if #(
   parameter int COMPONENT_BITS = 16
) ();
   import onc_pkg::*;

   logic                             valid;
   logic                             ready;
   logic [CODE_W-1:0]                code_out;
   logic signed [COMPONENT_BITS-1:0] x_out;
   logic signed [COMPONENT_BITS-1:0] y_out;
   logic signed [COMPONENT_BITS-1:0] z_out;
   logic                             zero_vector;

   modport source (output valid, code_out, x_out, y_out, z_out, zero_vector, input ready);
   modport sink   (input valid, code_out, x_out, y_out, z_out, zero_vector, output ready);
endinterface

### rtl/octahedral_normal_codec.sv
// top level: pipelined octahedral normal encoder and decoder
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+--------------------------------------
//   req_chan  | in  | valid / ready      | action, x_in, y_in, z_in, code_in
//   rsp_chan  | out | valid / ready      | code_out, x_out, y_out, z_out, zero_vector
//   csr       | in  | csr_we             | csr_wdata (code_bits)
//
// one beat enters per cycle while the skid register is empty
// the pipeline length is set by the bit-serial square root, one root bit per stage, the quotient
// bits of the encode divider ride in the first stages of the same pipeline
// reset clears all valid bits and loads code_bits with 16
// a stalled output beat moves into a skid register; the pipeline freezes only
// while the skid register is full, so no beat is lost or repeated
module octahedral_normal_codec #(
   parameter int MAX_CODE_BITS  = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   onc_req_if.sink                   req_chan,
   onc_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [onc_pkg::CFG_W-1:0] csr_wdata
);
   import onc_pkg::*;

   localparam int CB    = COMPONENT_BITS;
   localparam int H_MAX = MAX_CODE_BITS / 2;
   localparam int HW    = $clog2(H_MAX + 1);
   localparam int QB    = H_MAX + 1;
   localparam int LW    = CB + 1;
   localparam int DW    = CB + 2;
   localparam int NUMW  = DW + H_MAX;
   localparam int SW    = NUMW + 2;
   localparam int AW    = H_MAX + 2;
   localparam int N2W   = 2 * (AW - 1);
   localparam int NW    = N2W + 2 * CB;
   localparam int WW    = NW + 2;
   localparam int FB    = CB + 1;
   localparam int NP    = FB + 4;
   localparam int ES    = QB + 2;
   localparam int MW    = CODE_W + 1;

   typedef struct packed {
      logic                 act;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic [CODE_W-1:0]    code;
   } in_type;

   typedef struct packed {
      logic                 act;
      logic                 zero;
      logic                 zpos;
      logic                 ulm;
      logic                 vlm;
      logic [NUMW-1:0]      numu;
      logic [NUMW-1:0]      numv;
      logic [DW-1:0]        den;
      logic signed [AW-1:0] a;
      logic signed [AW-1:0] b;
      logic signed [AW-1:0] c;
   } s1_type;

   typedef struct packed {
      logic                      act;
      logic                      zero;
      logic                      zpos;
      logic                      ulm;
      logic                      vlm;
      logic [NUMW-1:0]           numu;
      logic [NUMW-1:0]           numv;
      logic [DW-1:0]             den;
      logic [2:0]                neg;
      logic [2:0][N2W-1:0]       sq;
   } s2_type;

   typedef struct packed {
      logic                act;
      logic                zero;
      logic                zpos;
      logic                ulm;
      logic                vlm;
      logic [NUMW-1:0]     rem_u;
      logic [NUMW-1:0]     rem_v;
      logic [DW-1:0]       den;
      logic [QB-1:0]       q_u;
      logic [QB-1:0]       q_v;
      logic [N2W-1:0]      n2;
      logic [2:0]          neg;
      logic [2:0][NW-1:0]  tgt;
      logic [2:0][WW-1:0]  acc_p;
      logic [2:0][WW-1:0]  acc_g;
      logic [2:0][FB-1:0]  root;
   } iter_type;

   typedef struct packed {
      logic [CODE_W-1:0]    code;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic                 zero;
   } res_type;

   // configuration register and effective bit count
   logic [CFG_W-1:0] code_bits_ff;
   logic [CFG_W-1:0] cbe;
   logic             odd;
   logic [HW-1:0]    h;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff <= CODE_BITS_RESET;
      end else if (csr_we) begin
         code_bits_ff <= csr_wdata;
      end
   end

   always_comb begin
      cbe = code_bits_ff;
      if (code_bits_ff < CODE_BITS_MIN) begin
         cbe = CODE_BITS_MIN;
      end else if (code_bits_ff > CFG_W'(MAX_CODE_BITS)) begin
         cbe = CFG_W'(MAX_CODE_BITS);
      end
      odd = cbe[0];
      h   = HW'(cbe >> 1);
   end

   // pipeline valid bits advance together while the skid register is empty
   logic [NP-1:0] pv_ff;
   logic          adv;
   logic          skid_v_ff;

   assign adv            = !skid_v_ff;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[NP-2:0], req_chan.valid};
      end
   end

   // stage 0: request beat register
   in_type s0_ff, s0_in;

   always_comb begin
      s0_in.act  = req_chan.action;
      s0_in.x    = req_chan.x_in;
      s0_in.y    = req_chan.y_in;
      s0_in.z    = req_chan.z_in;
      s0_in.code = req_chan.code_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   // stage 1: l1 norm and scaled numerators, decode octahedron point
   s1_type                s1_ff, s1_in;
   logic [CB-1:0]         ax, ay, az;
   logic [LW-1:0]         l1;
   logic signed [SW-1:0]  sx, sy, sl, t_u, t_v, p_u, p_v;
   logic [MW-1:0]         full_mask;
   logic [CODE_W-1:0]     cm, m16, ui16, vi16, zsh;
   logic signed [AW-1:0]  n_s, m_s, ui_s, vi_s, a_s, b_s, abs_a, abs_b, mag;
   logic                  zsign;

   always_comb begin
      // encode side
      ax  = s0_ff.x[CB-1] ? (~s0_ff.x + 1'b1) : s0_ff.x;
      ay  = s0_ff.y[CB-1] ? (~s0_ff.y + 1'b1) : s0_ff.y;
      az  = s0_ff.z[CB-1] ? (~s0_ff.z + 1'b1) : s0_ff.z;
      l1  = LW'(ax) + LW'(ay) + LW'(az);
      sx  = SW'(s0_ff.x);
      sy  = SW'(s0_ff.y);
      sl  = SW'(l1);
      t_u = '0;
      t_v = '0;
      p_u = '0;
      p_v = '0;
      if (odd) begin
         t_u = sx + sy + sl;
         t_v = sx - sy + sl;
         p_u = t_u << h;
         p_v = t_v << h;
      end else if (!s0_ff.z[CB-1] && (s0_ff.z != '0)) begin
         t_u = sx + sl;
         p_u = (t_u << h) - t_u;
         p_v = (sy << h) - sy + (sl << h);
      end else begin
         t_v = sy + sl;
         p_u = (sx << h) - sx + (sl << h);
         p_v = (t_v << h) - t_v;
      end
      s1_in.act  = s0_ff.act;
      s1_in.zero = (s0_ff.act == ACT_ENCODE) && (l1 == '0);
      s1_in.zpos = !s0_ff.z[CB-1] && (s0_ff.z != '0);
      s1_in.ulm  = !odd && s1_in.zpos;
      s1_in.vlm  = !odd && !s1_in.zpos;
      s1_in.numu = p_u[NUMW-1:0];
      s1_in.numv = p_v[NUMW-1:0];
      s1_in.den  = {l1, 1'b0};

      // decode side
      full_mask = (MW'(1) << cbe) - MW'(1);
      cm        = s0_ff.code & full_mask[CODE_W-1:0];
      m16       = (CODE_W'(1) << h) - CODE_W'(1);
      ui16      = cm & m16;
      vi16      = (cm >> h) & m16;
      zsh       = cm >> {h, 1'b0};
      n_s       = AW'(1) << h;
      m_s       = n_s - AW'(1);
      ui_s      = signed'({2'b00, ui16[H_MAX-1:0]});
      vi_s      = signed'({2'b00, vi16[H_MAX-1:0]});
      a_s       = odd ? (ui_s + vi_s + AW'(1) - n_s) : (ui_s + vi_s - m_s);
      b_s       = ui_s - vi_s;
      abs_a     = a_s[AW-1] ? -a_s : a_s;
      abs_b     = b_s[AW-1] ? -b_s : b_s;
      mag       = (odd ? n_s : m_s) - abs_a - abs_b;
      zsign     = odd ? zsh[0] : (ui16[0] ^ vi16[0]);
      s1_in.a   = a_s;
      s1_in.b   = b_s;
      s1_in.c   = zsign ? mag : -mag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: squares of the three decode components
   s2_type             s2_ff, s2_in;
   logic [2:0][AW-2:0] mag_c;
   logic [2:0]         neg_c;

   always_comb begin
      neg_c[0] = s1_ff.a[AW-1];
      neg_c[1] = s1_ff.b[AW-1];
      neg_c[2] = s1_ff.c[AW-1];
      mag_c[0] = neg_c[0] ? (AW-1)'(-s1_ff.a) : (AW-1)'(s1_ff.a);
      mag_c[1] = neg_c[1] ? (AW-1)'(-s1_ff.b) : (AW-1)'(s1_ff.b);
      mag_c[2] = neg_c[2] ? (AW-1)'(-s1_ff.c) : (AW-1)'(s1_ff.c);
      s2_in.act  = s1_ff.act;
      s2_in.zero = s1_ff.zero;
      s2_in.zpos = s1_ff.zpos;
      s2_in.ulm  = s1_ff.ulm;
      s2_in.vlm  = s1_ff.vlm;
      s2_in.numu = s1_ff.numu;
      s2_in.numv = s1_ff.numv;
      s2_in.den  = s1_ff.den;
      s2_in.neg  = neg_c;
      for (int i = 0; i < 3; i++) begin
         s2_in.sq[i] = N2W'(mag_c[i] * mag_c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: squared norm and per-component root targets
   iter_type st3_ff, st3_in;

   always_comb begin
      st3_in.act   = s2_ff.act;
      st3_in.zero  = s2_ff.zero;
      st3_in.zpos  = s2_ff.zpos;
      st3_in.ulm   = s2_ff.ulm;
      st3_in.vlm   = s2_ff.vlm;
      st3_in.rem_u = s2_ff.numu;
      st3_in.rem_v = s2_ff.numv;
      st3_in.den   = s2_ff.den;
      st3_in.q_u   = '0;
      st3_in.q_v   = '0;
      st3_in.n2    = N2W'(s2_ff.sq[0] + s2_ff.sq[1] + s2_ff.sq[2]);
      st3_in.neg   = s2_ff.neg;
      st3_in.acc_p = '0;
      st3_in.acc_g = '0;
      st3_in.root  = '0;
      for (int i = 0; i < 3; i++) begin
         st3_in.tgt[i] = NW'(s2_ff.sq[i]) << (2 * CB);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st3_ff <= st3_in;
      end
   end

   // root and quotient stages: one root bit per component in each stage, and one
   // quotient bit per index in each of the first QB stages
   iter_type it_ff [FB];
   iter_type it_in [FB];

   for (genvar j = 0; j < FB; j++) begin : g_iter
      localparam int K      = FB - 1 - j;
      localparam bit DO_DIV = (j < QB);
      localparam int KD     = DO_DIV ? (QB - 1 - j) : 0;
      iter_type prv, nxt;

      if (j == 0) begin : g_first
         assign prv = st3_ff;
      end else begin : g_rest
         assign prv = it_ff[j-1];
      end

      always_comb begin
         logic [WW-1:0]   trial;
         logic [NUMW:0]   dv;
         nxt = prv;
         // restoring square root step, f^2 * n2 kept incrementally
         for (int i = 0; i < 3; i++) begin
            trial = prv.acc_p[i] + (prv.acc_g[i] << (K + 1)) + (WW'(prv.n2) << (2 * K));
            if (trial <= WW'(prv.tgt[i])) begin
               nxt.acc_p[i]   = trial;
               nxt.acc_g[i]   = prv.acc_g[i] + (WW'(prv.n2) << K);
               nxt.root[i][K] = 1'b1;
            end
         end
         // restoring division step for both indices
         dv = (NUMW + 1)'(prv.den) << KD;
         if (DO_DIV) begin
            if ((NUMW + 1)'(prv.rem_u) >= dv) begin
               nxt.rem_u   = NUMW'((NUMW + 1)'(prv.rem_u) - dv);
               nxt.q_u[KD] = 1'b1;
            end
            if ((NUMW + 1)'(prv.rem_v) >= dv) begin
               nxt.rem_v   = NUMW'((NUMW + 1)'(prv.rem_v) - dv);
               nxt.q_v[KD] = 1'b1;
            end
         end
      end

      assign it_in[j] = nxt;

      always_ff @(posedge clock) begin
         if (adv) begin
            it_ff[j] <= it_in[j];
         end
      end
   end

   // result shaping: index clamp and code packing, or rounding and saturation
   iter_type             lst;
   res_type              res;
   logic [QB-1:0]        n_q, m_q, half_q, lim_u, lim_v, cu, cv;
   logic signed [ES-1:0] eu, ev, em;
   logic [QB-1:0]        uo, vo;
   logic [CB-1:0]        qv;
   logic [CB-1:0]        smax;
   logic [CB-1:0]        comp [3];

   assign lst = it_ff[FB-1];

   always_comb begin
      n_q    = QB'(1) << h;
      m_q    = n_q - QB'(1);
      half_q = n_q >> 1;
      lim_u  = lst.ulm ? m_q : n_q;
      lim_v  = lst.vlm ? m_q : n_q;
      cu     = (lst.q_u > lim_u - QB'(1)) ? (lim_u - QB'(1)) : lst.q_u;
      cv     = (lst.q_v > lim_v - QB'(1)) ? (lim_v - QB'(1)) : lst.q_v;
      em     = signed'(ES'(m_q));
      eu     = signed'(ES'(cu)) + signed'(ES'(cv)) - signed'(ES'(half_q)) + ES'(1);
      ev     = signed'(ES'(cu)) - signed'(ES'(cv)) + signed'(ES'(half_q));
      if (!lst.zpos) begin
         ev = ev - ES'(1);
      end
      if (eu[ES-1]) begin
         eu = '0;
      end else if (eu > em) begin
         eu = em;
      end
      if (ev[ES-1]) begin
         ev = '0;
      end else if (ev > em) begin
         ev = em;
      end
      uo = odd ? cu : QB'(eu);
      vo = odd ? cv : QB'(ev);

      smax = {1'b1, {(CB - 1){1'b0}}};
      for (int i = 0; i < 3; i++) begin
         qv = CB'((FB + 1)'(lst.root[i]) + (FB + 1)'(1) >> 1);
         if (lst.n2 == '0) begin
            comp[i] = '0;
         end else if (lst.neg[i]) begin
            comp[i] = -qv;
         end else if (qv >= smax) begin
            comp[i] = smax - CB'(1);
         end else begin
            comp[i] = qv;
         end
      end

      res = '0;
      if (lst.act == ACT_ENCODE) begin
         res.zero = lst.zero;
         if (!lst.zero) begin
            res.code = (CODE_W'(vo) << h) | CODE_W'(uo) |
                       (CODE_W'(odd && lst.zpos) << {h, 1'b0});
         end
      end else begin
         res.x = comp[0];
         res.y = comp[1];
         res.z = comp[2];
      end
   end

   // output register with skid register behind it
   res_type out_ff, out_in, skid_ff, skid_in;
   logic    out_v_ff, out_v_in, skid_v_in;
   logic    take, push;

   assign push = adv && pv_ff[NP-1];
   assign take = rsp_chan.ready || !out_v_ff;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (take) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            out_in   = res;
            out_v_in = push;
         end
      end else if (push) begin
         skid_in   = res;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.code_out    = out_ff.code;
   assign rsp_chan.x_out       = out_ff.x;
   assign rsp_chan.y_out       = out_ff.y;
   assign rsp_chan.z_out       = out_ff.z;
   assign rsp_chan.zero_vector = out_ff.zero;

   // accepted beat shows up in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> pv_ff[0])
      else $error("accepted beat missing from first stage");

   // skid register only fills behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   // a zero vector always carries code zero
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_vector |-> rsp_chan.code_out == '0)
      else $error("zero vector with nonzero code");

endmodule
